/* rtl/core/ordered_array_insert_erase_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array core
// Short forms for clocked checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH
`define ORDERED_ARRAY_INSERT_ERASE_CORE_MACROS_SVH

// Same-cycle implication.
`define OAIE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("oaie assertion failed");

// Next-cycle implication.
`define OAIE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("oaie assertion failed");

`endif

/* rtl/core/oaie_pkg.sv */
// ----------------------------------------------------------------------------
// oaie_pkg
// Command and status codes, cell control struct and default sizes.
// ----------------------------------------------------------------------------
package oaie_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int WORD_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		CMD_READ        = 3'd0,
		CMD_APPEND      = 3'd1,
		CMD_REMOVE_LAST = 3'd2,
		CMD_INSERT      = 3'd3,
		CMD_ERASE       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// Per-transaction control broadcast to every cell.
	typedef struct packed {
		logic rd;
		logic append;
		logic insert;
		logic erase;
	} cell_op_t;

endpackage

/* rtl/core/oaie_cell.sv */
// ----------------------------------------------------------------------------
// oaie_cell
// One storage slot of the list: holds, loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module oaie_cell #(
	parameter int IDX        = 0,
	parameter int WORD_WIDTH = 32,
	parameter int CNT_WIDTH  = 7
) (
	input  logic                    clk,
	input  oaie_pkg::cell_op_t      op,
	input  logic [CNT_WIDTH-1:0]    position,
	input  logic [CNT_WIDTH-1:0]    count,
	input  logic [WORD_WIDTH-1:0]   word_in,
	input  logic [WORD_WIDTH-1:0]   left_word,
	input  logic [WORD_WIDTH-1:0]   right_word,
	output logic [WORD_WIDTH-1:0]   word,
	output logic [WORD_WIDTH-1:0]   rd_word
);
	import oaie_pkg::*;

	localparam logic [CNT_WIDTH-1:0] MyIdx = CNT_WIDTH'(IDX);

	logic [WORD_WIDTH-1:0] word_q;
	logic at_pos;
	logic above_pos;

	assign at_pos    = (position == MyIdx);
	assign above_pos = (MyIdx > position);

	// Op bits are one-hot; with none set the cell holds.
	always_ff @(posedge clk) begin
		if (op.append && (count == MyIdx)) begin
			word_q <= word_in;
		end else if (op.insert && at_pos) begin
			word_q <= word_in;
		end else if (op.insert && above_pos) begin
			word_q <= left_word;
		end else if (op.erase && (at_pos || above_pos)) begin
			word_q <= right_word;
		end
	end

	assign word    = word_q;
	assign rd_word = (op.rd && at_pos) ? word_q : '0;

endmodule

/* rtl/core/oaie_ctrl.sv */
// ----------------------------------------------------------------------------
// oaie_ctrl
// Command decode, range checks and the entry count register.
// ----------------------------------------------------------------------------
module oaie_ctrl #(
	parameter int CAPACITY  = 64,
	parameter int CNT_WIDTH = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [2:0]            command,
	input  logic [CNT_WIDTH-1:0]  position,
	output oaie_pkg::cell_op_t    op,
	output oaie_pkg::status_t     status,
	output logic [CNT_WIDTH-1:0]  count,
	output logic [CNT_WIDTH-1:0]  count_next
);
	import oaie_pkg::*;

	localparam logic [CNT_WIDTH-1:0] Cap = CNT_WIDTH'(CAPACITY);

	logic [CNT_WIDTH-1:0] count_q;
	logic                 full;
	logic                 empty;
	cell_op_t             op_raw;

	assign full  = (count_q == Cap);
	assign empty = (count_q == '0);

	always_comb begin
		op_raw     = '0;
		status     = ST_OK;
		count_next = count_q;
		unique case (cmd_t'(command))
			CMD_READ: begin
				if (position >= count_q) status = ST_RANGE;
				else op_raw.rd = 1'b1;
			end
			CMD_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					op_raw.append = 1'b1;
					count_next    = count_q + 1'b1;
				end
			end
			CMD_REMOVE_LAST: begin
				if (empty) status = ST_EMPTY;
				else count_next = count_q - 1'b1;
			end
			CMD_INSERT: begin
				if (position > count_q) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					op_raw.insert = 1'b1;
					count_next    = count_q + 1'b1;
				end
			end
			CMD_ERASE: begin
				if (position >= count_q) begin
					status = ST_RANGE;
				end else begin
					op_raw.erase = 1'b1;
					count_next   = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign op    = accept ? op_raw : '0;
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

endmodule

/* rtl/core/ordered_array_insert_erase_core.sv */
// ----------------------------------------------------------------------------
// ordered_array_insert_erase_core
// Fixed-capacity ordered list of signed words with insert and erase.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY register cells; cell i holds entry i.
// When a command transaction is taken, its result transaction
// (word read, status, count after the command) appears in the result register
// on the next cycle. Insert and erase move every later entry by one place in
// that same cycle, because each cell loads from its left or right neighbor in
// parallel, so one command can be taken every cycle; the only throttle is the
// single result register, and cmd_stall is raised only while a result waits
// and rsp_stall is high. Reads pick the addressed cell through an OR tree
// across the row. Failed commands (bad index, empty list, full store) leave
// the list and the count untouched. No clearing pass after reset: only the
// count is reset, and entries at or above it are never read.
// ----------------------------------------------------------------------------
`include "ordered_array_insert_erase_core_macros.svh"

module ordered_array_insert_erase_core #(
	parameter int CAPACITY   = oaie_pkg::CAPACITY_DEF,
	parameter int WORD_WIDTH = oaie_pkg::WORD_WIDTH_DEF,
	parameter int CNT_WIDTH  = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// command channel
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [2:0]                   command,
	input  logic [CNT_WIDTH-1:0]         position,
	input  logic signed [WORD_WIDTH-1:0] word_in,

	// result channel
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [WORD_WIDTH-1:0] word_out,
	output logic [1:0]                   status,
	output logic [CNT_WIDTH-1:0]         entry_count
);
	import oaie_pkg::*;

	logic                  accept;
	cell_op_t              op;
	status_t               ctrl_status;
	logic [CNT_WIDTH-1:0]  ctrl_count;
	logic [CNT_WIDTH-1:0]  ctrl_count_next;

	logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
	logic [WORD_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [WORD_WIDTH-1:0] rd_word;

	logic                  rsp_valid_q;
	logic [WORD_WIDTH-1:0] word_out_q;
	status_t               status_q;
	logic [CNT_WIDTH-1:0]  count_out_q;

	// Take a command whenever the result register is free or draining.
	assign cmd_stall = rsp_valid_q && rsp_stall;
	assign accept    = cmd_valid && !cmd_stall;

	oaie_ctrl #(
		.CAPACITY  (CAPACITY),
		.CNT_WIDTH (CNT_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.position   (position),
		.op         (op),
		.status     (ctrl_status),
		.count      (ctrl_count),
		.count_next (ctrl_count_next)
	);

	// Row of cells; each neighbor link carries the shift path.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_word[i];
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		oaie_cell #(
			.IDX        (i),
			.WORD_WIDTH (WORD_WIDTH),
			.CNT_WIDTH  (CNT_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.position   (position),
			.count      (ctrl_count),
			.word_in    (word_in),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rd_word    (cell_rd[i])
		);
	end

	// At most one cell drives a nonzero read word.
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	// Result register: payload has no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_out_q  <= rd_word;
			status_q    <= ctrl_status;
			count_out_q <= ctrl_count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign word_out    = word_out_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

	// Count never runs past the store.
	`OAIE_ASSERT_SAME(a_count_bound, 1'b1, ctrl_count <= CNT_WIDTH'(CAPACITY))
	// A failed command leaves the count alone.
	`OAIE_ASSERT_NEXT(a_fail_keeps_count, accept && (ctrl_status != ST_OK),
		ctrl_count == $past(ctrl_count))
	// Every taken command yields a pending result.
	`OAIE_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_valid_q)
	// Word is only nonzero for a successful transaction.
	`OAIE_ASSERT_SAME(a_err_zero_word, rsp_valid_q && (status_q != ST_OK), word_out_q == '0)

endmodule
